>>> rtl/dftp_pkg.sv
package dftp_pkg;

	// operation codes handed from the front to the back
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_CTRL = 2'd2;
	localparam logic [1:0] OP_CFG  = 2'd3;

	// register indexes on the APB port
	localparam logic [2:0] REG_CTRL_HEAD_FIRST  = 3'd0;
	localparam logic [2:0] REG_CTRL_HEAD_SECOND = 3'd1;
	localparam logic [2:0] REG_CTRL_TAIL_BYTE   = 3'd2;
	localparam logic [2:0] REG_CFG_HEAD_FIRST   = 3'd3;
	localparam logic [2:0] REG_CFG_HEAD_SECOND  = 3'd4;
	localparam logic [2:0] REG_CFG_TAIL_BYTE    = 3'd5;
	localparam logic [2:0] REG_LINK_TIMEOUT_MS  = 3'd6;

	// register reset values
	localparam logic [7:0]  RST_CTRL_HEAD_FIRST  = 8'd165;
	localparam logic [7:0]  RST_CTRL_HEAD_SECOND = 8'd90;
	localparam logic [7:0]  RST_CTRL_TAIL_BYTE   = 8'd238;
	localparam logic [7:0]  RST_CFG_HEAD_FIRST   = 8'd195;
	localparam logic [7:0]  RST_CFG_HEAD_SECOND  = 8'd60;
	localparam logic [7:0]  RST_CFG_TAIL_BYTE    = 8'd221;
	localparam logic [31:0] RST_LINK_TIMEOUT_MS  = 32'd500;

	// control frame key decode
	localparam logic [3:0] KEY_MAX  = 4'd11;
	localparam logic [7:0] KEY_NONE = 8'hFF;

	localparam int PAYLOAD_BYTES = 6;
	localparam int CELLS_MAX     = 24;

	// header and tail bytes of both frame kinds
	typedef struct packed {
		logic [7:0] ctrl_head_first;
		logic [7:0] ctrl_head_second;
		logic [7:0] ctrl_tail_byte;
		logic [7:0] cfg_head_first;
		logic [7:0] cfg_head_second;
		logic [7:0] cfg_tail_byte;
	} dftp_frame_cfg_t;

	// one queued operation: P0 sits in payload[7:0]
	typedef struct packed {
		logic [1:0]                   op;
		logic [8*PAYLOAD_BYTES-1:0]   payload;
		logic [31:0]                  now_ms;
	} dftp_item_t;

endpackage

>>> rtl/dftp_front.sv
module dftp_front import dftp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  dftp_frame_cfg_t frame_cfg,
	input  logic            accept,
	input  logic            req_type,
	input  logic [7:0]      rx_byte,
	input  logic [31:0]     now_ms,
	output dftp_item_t      item
);

	localparam logic [1:0] PH_HEAD0 = 2'd0;
	localparam logic [1:0] PH_HEAD1 = 2'd1;
	localparam logic [1:0] PH_BODY  = 2'd2;
	localparam logic [1:0] PH_TAIL  = 2'd3;

	localparam logic [3:0] POS_HEAD1 = 4'd1;
	localparam logic [3:0] POS_FIRST = 4'd2;
	localparam logic [3:0] POS_LAST  = 4'd7;

	logic [1:0] phase_q, phase_d;
	logic [3:0] pos_q, pos_d;
	logic       kind_q, kind_d;
	logic [7:0] payload_q [PAYLOAD_BYTES];
	logic       store_en;
	logic [2:0] wr_idx;
	logic [1:0] op;
	logic [7:0] head_want, tail_want;

	assign head_want = kind_q ? frame_cfg.cfg_head_second : frame_cfg.ctrl_head_second;
	assign tail_want = kind_q ? frame_cfg.cfg_tail_byte : frame_cfg.ctrl_tail_byte;
	assign wr_idx    = pos_q[2:0] - POS_FIRST[2:0];

	// byte framing state machine
	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		kind_d   = kind_q;
		store_en = 1'b0;
		op       = OP_NONE;
		if (req_type) begin
			op = OP_ACK;
		end else begin
			unique case (phase_q)
				PH_HEAD0: begin
					if (rx_byte == frame_cfg.ctrl_head_first) begin
						kind_d  = 1'b0;
						pos_d   = POS_HEAD1;
						phase_d = PH_HEAD1;
					end else if (rx_byte == frame_cfg.cfg_head_first) begin
						kind_d  = 1'b1;
						pos_d   = POS_HEAD1;
						phase_d = PH_HEAD1;
					end
				end
				PH_HEAD1: begin
					if (rx_byte == head_want) begin
						pos_d   = POS_FIRST;
						phase_d = PH_BODY;
					end else if (rx_byte == frame_cfg.ctrl_head_first) begin
						// restart as control
						kind_d = 1'b0;
						pos_d  = POS_HEAD1;
					end else if (rx_byte == frame_cfg.cfg_head_first) begin
						// restart as config
						kind_d = 1'b1;
						pos_d  = POS_HEAD1;
					end else begin
						phase_d = PH_HEAD0;
					end
				end
				PH_BODY: begin
					if (pos_q >= POS_FIRST && pos_q <= POS_LAST) begin
						store_en = 1'b1;
						pos_d    = pos_q + 4'd1;
						if (pos_q == POS_LAST) begin
							phase_d = PH_TAIL;
						end
					end else begin
						phase_d = PH_TAIL;
					end
				end
				PH_TAIL: begin
					if (rx_byte == tail_want) begin
						op = kind_q ? OP_CFG : OP_CTRL;
					end
					phase_d = PH_HEAD0;
					pos_d   = 4'd0;
				end
				default: begin
					phase_d = PH_HEAD0;
				end
			endcase
		end
	end

	// parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD0;
			pos_q   <= 4'd0;
			kind_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			kind_q  <= kind_d;
		end
	end

	// payload bytes, no reset
	always_ff @(posedge clk) begin
		for (int j = 0; j < PAYLOAD_BYTES; j++) begin
			if (accept && store_en && wr_idx == 3'(j)) begin
				payload_q[j] <= rx_byte;
			end
		end
	end

	// operation handed to the queue
	always_comb begin
		item.op     = op;
		item.now_ms = now_ms;
		for (int j = 0; j < PAYLOAD_BYTES; j++) begin
			item.payload[8*j +: 8] = payload_q[j];
		end
	end

endmodule

>>> rtl/dftp_queue.sv
module dftp_queue import dftp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  dftp_item_t push_item,
	input  logic       pop,
	output dftp_item_t pop_item,
	output logic       empty,
	output logic       full
);

	dftp_item_t slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign empty    = (count_q == 2'd0);
	assign full     = (count_q == 2'd2);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/dftp_back.sv
module dftp_back import dftp_pkg::*; #(
	parameter int CELLS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] link_timeout_ms,
	input  dftp_item_t  item,
	input  logic        item_ready,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_done,
	output logic        frame_is_config,
	output logic [7:0]  key_q,
	output logic [3:0]  mode_q,
	output logic [7:0]  button_q,
	output logic [31:0] axis_q,
	output logic [47:0] cell_q,
	output logic        pending_q,
	output logic        link_alive
);

	logic        out_valid_q, done_q, is_cfg_q, alive_q;
	logic [31:0] tick_q, tick_d;
	logic [47:0] cell_d;
	logic [3:0]  key_hi;
	logic        is_frame;

	assign pop             = item_ready && (!out_valid_q || !out_stall);
	assign out_valid       = out_valid_q;
	assign frame_done      = done_q;
	assign frame_is_config = is_cfg_q;
	assign link_alive      = alive_q;

	assign is_frame = (item.op == OP_CTRL) || (item.op == OP_CFG);
	assign tick_d   = is_frame ? item.now_ms : tick_q;
	assign key_hi   = item.payload[7:4];

	// unpack the config cells
	always_comb begin
		cell_d = cell_q;
		for (int i = 0; i < CELLS; i++) begin
			cell_d[2*i +: 2] = item.payload[8*(i >> 2) + 2*(3 - (i & 3)) +: 2];
		end
	end

	// output beat and decoded stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
			is_cfg_q    <= 1'b0;
			alive_q     <= 1'b0;
			tick_q      <= 32'd0;
			key_q       <= KEY_NONE;
			mode_q      <= 4'd0;
			button_q    <= 8'd0;
			axis_q      <= 32'd0;
			cell_q      <= 48'd0;
			pending_q   <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				done_q      <= is_frame;
				is_cfg_q    <= (item.op == OP_CFG);
				tick_q      <= tick_d;
				alive_q     <= (tick_d != 32'd0) && ((item.now_ms - tick_d) < link_timeout_ms);
				unique case (item.op)
					OP_ACK: begin
						pending_q <= 1'b0;
					end
					OP_CTRL: begin
						key_q    <= (key_hi <= KEY_MAX) ? {4'd0, key_hi} : KEY_NONE;
						mode_q   <= item.payload[3:0];
						button_q <= item.payload[15:8];
						axis_q   <= item.payload[47:16];
					end
					OP_CFG: begin
						cell_q    <= cell_d;
						pending_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/dual_frame_telemetry_parser_unit.sv
// An accepted byte is written into the two-entry queue between the framing front and the
// decode back, then popped into the result registers; a stalled result beat holds it there.
// Throughput: one beat per cycle while the output does not stall; the queue takes one
// more beat (two if it was empty) while the output stalls.
// Reset (arst_n low, asynchronous): parser waits for a first header, key reads 255, other
// stores, pending flag and frame stamp clear; registers reload defaults; payload not reset.
module dual_frame_telemetry_parser_unit import dftp_pkg::*; #(
	parameter int CELLS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              req_type,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       now_ms,
	// result channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              frame_done,
	output logic              frame_is_config,
	output logic [7:0]        key_index,
	output logic [3:0]        mode_flags,
	output logic [7:0]        button_flags,
	output logic signed [7:0] throttle_axis,
	output logic signed [7:0] steering_axis,
	output logic signed [7:0] strafe_axis,
	output logic signed [7:0] lift_axis,
	output logic [47:0]       cell_map,
	output logic              config_pending,
	output logic              link_alive
);

	dftp_frame_cfg_t frame_cfg_q;
	logic [31:0]     timeout_q;
	logic [2:0]      reg_idx;
	logic            reg_wr;
	logic            in_accept;
	dftp_item_t      front_item, back_item;
	logic            q_empty, q_full, q_pop;
	logic [31:0]     axis;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cfg_q.ctrl_head_first  <= RST_CTRL_HEAD_FIRST;
			frame_cfg_q.ctrl_head_second <= RST_CTRL_HEAD_SECOND;
			frame_cfg_q.ctrl_tail_byte   <= RST_CTRL_TAIL_BYTE;
			frame_cfg_q.cfg_head_first   <= RST_CFG_HEAD_FIRST;
			frame_cfg_q.cfg_head_second  <= RST_CFG_HEAD_SECOND;
			frame_cfg_q.cfg_tail_byte    <= RST_CFG_TAIL_BYTE;
			timeout_q                    <= RST_LINK_TIMEOUT_MS;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_CTRL_HEAD_FIRST:  frame_cfg_q.ctrl_head_first  <= pwdata[7:0];
				REG_CTRL_HEAD_SECOND: frame_cfg_q.ctrl_head_second <= pwdata[7:0];
				REG_CTRL_TAIL_BYTE:   frame_cfg_q.ctrl_tail_byte   <= pwdata[7:0];
				REG_CFG_HEAD_FIRST:   frame_cfg_q.cfg_head_first   <= pwdata[7:0];
				REG_CFG_HEAD_SECOND:  frame_cfg_q.cfg_head_second  <= pwdata[7:0];
				REG_CFG_TAIL_BYTE:    frame_cfg_q.cfg_tail_byte    <= pwdata[7:0];
				REG_LINK_TIMEOUT_MS:  timeout_q                    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_CTRL_HEAD_FIRST:  prdata = {24'd0, frame_cfg_q.ctrl_head_first};
			REG_CTRL_HEAD_SECOND: prdata = {24'd0, frame_cfg_q.ctrl_head_second};
			REG_CTRL_TAIL_BYTE:   prdata = {24'd0, frame_cfg_q.ctrl_tail_byte};
			REG_CFG_HEAD_FIRST:   prdata = {24'd0, frame_cfg_q.cfg_head_first};
			REG_CFG_HEAD_SECOND:  prdata = {24'd0, frame_cfg_q.cfg_head_second};
			REG_CFG_TAIL_BYTE:    prdata = {24'd0, frame_cfg_q.cfg_tail_byte};
			REG_LINK_TIMEOUT_MS:  prdata = timeout_q;
			default:              prdata = 32'd0;
		endcase
	end

	assign in_stall  = q_full;
	assign in_accept = in_valid && !q_full;

	dftp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_cfg (frame_cfg_q),
		.accept    (in_accept),
		.req_type  (req_type),
		.rx_byte   (rx_byte),
		.now_ms    (now_ms),
		.item      (front_item)
	);

	dftp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_item (front_item),
		.pop       (q_pop),
		.pop_item  (back_item),
		.empty     (q_empty),
		.full      (q_full)
	);

	dftp_back #(
		.CELLS (CELLS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.link_timeout_ms (timeout_q),
		.item            (back_item),
		.item_ready      (!q_empty),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_done      (frame_done),
		.frame_is_config (frame_is_config),
		.key_q           (key_index),
		.mode_q          (mode_flags),
		.button_q        (button_flags),
		.axis_q          (axis),
		.cell_q          (cell_map),
		.pending_q       (config_pending),
		.link_alive      (link_alive)
	);

	assign throttle_axis = $signed(axis[7:0]);
	assign steering_axis = $signed(axis[15:8]);
	assign strafe_axis   = $signed(axis[23:16]);
	assign lift_axis     = $signed(axis[31:24]);

	// a full queue only happens behind a held result beat
	a_full_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("queue full without a pending result beat");

	// an acknowledge popped into the output clears the pending flag
	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && back_item.op == OP_ACK) |=> !config_pending)
		else $error("acknowledge did not clear pending flag");

	// a completed config frame always shows as pending
	a_cfg_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done && frame_is_config) |-> config_pending)
		else $error("config frame done without pending flag");

	// decoded key is a matrix key or none
	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_index <= {4'd0, KEY_MAX} || key_index == KEY_NONE))
		else $error("key index out of range");

endmodule

>>> tb/tb_dual_frame_telemetry_parser_unit.sv
module tb_dual_frame_telemetry_parser_unit import dftp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = 24;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {SEEK_HEAD0, SEEK_HEAD1, TAKE_BODY, SEEK_TAIL} parse_phase_t;

	// one decoded telemetry beat as seen on the result channel
	typedef struct packed {
		logic        done;
		logic        is_cfg;
		logic [7:0]  key;
		logic [3:0]  mode;
		logic [7:0]  buttons;
		logic [7:0]  throttle;
		logic [7:0]  steering;
		logic [7:0]  strafe;
		logic [7:0]  lift;
		logic [47:0] cells;
		logic        pending;
		logic        alive;
	} telemetry_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_done;
	logic        frame_is_config;
	logic [7:0]  key_index;
	logic [3:0]  mode_flags;
	logic [7:0]  button_flags;
	logic signed [7:0] throttle_axis;
	logic signed [7:0] steering_axis;
	logic signed [7:0] strafe_axis;
	logic signed [7:0] lift_axis;
	logic [47:0] cell_map;
	logic        config_pending;
	logic        link_alive;

	dual_frame_telemetry_parser_unit #(.CELLS(CELLS)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .rx_byte(rx_byte), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame_done(frame_done), .frame_is_config(frame_is_config),
		.key_index(key_index), .mode_flags(mode_flags), .button_flags(button_flags),
		.throttle_axis(throttle_axis), .steering_axis(steering_axis),
		.strafe_axis(strafe_axis), .lift_axis(lift_axis),
		.cell_map(cell_map), .config_pending(config_pending), .link_alive(link_alive)
	);

	// shadow of the register file and of the parser state
	logic [31:0]   reg_shadow [0:6];
	parse_phase_t  m_phase = SEEK_HEAD0;
	logic [7:0]    m_body [0:5];
	int unsigned   m_pos = 0;
	logic          m_kind_cfg = 1'b0;
	logic [31:0]   m_stamp = '0;
	logic [7:0]    m_key = KEY_NONE;
	logic [3:0]    m_mode = '0;
	logic [7:0]    m_buttons = '0;
	logic [31:0]   m_axes = '0;
	logic [47:0]   m_cells = '0;
	logic          m_pending = 1'b0;

	telemetry_t    telemetry_due [$];
	int unsigned   beats_sent = 0;
	int unsigned   fault_count = 0;
	logic [31:0]   tick = 32'd1000;
	logic          calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_fault(input string msg);
		fault_count++;
		$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_fault($sformatf("%s mismatch: got %0h, want %0h", name, got, want));
	endtask

	// header match opens a frame; control wins when both first headers agree
	function automatic void begin_frame(input logic [7:0] b);
		if (b == reg_shadow[REG_CTRL_HEAD_FIRST][7:0]) begin
			m_kind_cfg = 1'b0;
			m_pos = 1;
			m_phase = SEEK_HEAD1;
		end else if (b == reg_shadow[REG_CFG_HEAD_FIRST][7:0]) begin
			m_kind_cfg = 1'b1;
			m_pos = 1;
			m_phase = SEEK_HEAD1;
		end
	endfunction

	// advance the parser by one beat and return the result it should produce
	function automatic telemetry_t parse_byte(input logic ack, input logic [7:0] b,
			input logic [31:0] t);
		telemetry_t r;
		logic [7:0] want;
		logic [31:0] elapsed;
		int i;
		r = '0;
		if (ack) begin
			m_pending = 1'b0;
		end else begin
			case (m_phase)
				SEEK_HEAD0: begin_frame(b);
				SEEK_HEAD1: begin
					want = m_kind_cfg ? reg_shadow[REG_CFG_HEAD_SECOND][7:0]
						: reg_shadow[REG_CTRL_HEAD_SECOND][7:0];
					if (b == want) begin
						m_pos = 2;
						m_phase = TAKE_BODY;
					end else if (b == reg_shadow[REG_CTRL_HEAD_FIRST][7:0] ||
							b == reg_shadow[REG_CFG_HEAD_FIRST][7:0]) begin
						begin_frame(b);
					end else begin
						m_phase = SEEK_HEAD0;
					end
				end
				TAKE_BODY: begin
					m_body[m_pos - 2] = b;
					m_pos++;
					if (m_pos == 8)
						m_phase = SEEK_TAIL;
				end
				default: begin
					want = m_kind_cfg ? reg_shadow[REG_CFG_TAIL_BYTE][7:0]
						: reg_shadow[REG_CTRL_TAIL_BYTE][7:0];
					if (b == want) begin
						m_stamp = t;
						if (m_kind_cfg) begin
							// cells packed MSB-first within each payload byte
							for (i = 0; i < CELLS; i++)
								m_cells[2*i +: 2] = 2'(m_body[i/4] >> (2 * (3 - i % 4)));
							m_pending = 1'b1;
						end else begin
							m_key = (m_body[0][7:4] <= KEY_MAX) ? {4'd0, m_body[0][7:4]}
								: KEY_NONE;
							m_mode = m_body[0][3:0];
							m_buttons = m_body[1];
							m_axes = {m_body[5], m_body[4], m_body[3], m_body[2]};
						end
						r.done = 1'b1;
						r.is_cfg = m_kind_cfg;
					end
					m_phase = SEEK_HEAD0;
					m_pos = 0;
				end
			endcase
		end
		elapsed = t - m_stamp;
		r.key = m_key;
		r.mode = m_mode;
		r.buttons = m_buttons;
		{r.lift, r.strafe, r.steering, r.throttle} = m_axes;
		r.cells = m_cells;
		r.pending = m_pending;
		r.alive = (m_stamp != 32'd0) && (elapsed < reg_shadow[REG_LINK_TIMEOUT_MS]);
		return r;
	endfunction

	// present one beat, hold it until taken, then record what it should produce
	task automatic send_beat(input logic ack, input logic [7:0] b, input logic [31:0] t);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= ack;
		rx_byte <= b;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		telemetry_due.push_back(parse_byte(ack, b, t));
		beats_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (telemetry_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_LINK_TIMEOUT_MS)
			reg_shadow[idx] = val;
		else if (idx < REG_LINK_TIMEOUT_MS)
			reg_shadow[idx] = {24'd0, val[7:0]};
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [2:0] idx);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field($sformatf("register %0d readback", idx), 64'(prdata),
			64'(reg_shadow[idx]));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_settings(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] ct, input logic [7:0] g0, input logic [7:0] g1,
			input logic [7:0] gt, input logic [31:0] timeout);
		apb_write(REG_CTRL_HEAD_FIRST, {8'($urandom_range(255)), 16'd0, c0});
		apb_write(REG_CTRL_HEAD_SECOND, {24'd0, c1});
		apb_write(REG_CTRL_TAIL_BYTE, {24'd0, ct});
		apb_write(REG_CFG_HEAD_FIRST, {24'd0, g0});
		apb_write(REG_CFG_HEAD_SECOND, {24'd0, g1});
		apb_write(REG_CFG_TAIL_BYTE, {24'd0, gt});
		apb_write(REG_LINK_TIMEOUT_MS, timeout);
	endtask

	// mostly small steps, now and then a jump or a spot just short of the wrap
	function automatic logic [31:0] next_tick();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 2)
			tick = $urandom();
		else if (roll < 3)
			tick = 32'hFFFF_FFC0;
		else
			tick = tick + $urandom_range(90);
		return tick;
	endfunction

	// stray bytes lean toward header and tail values to hit the restart paths
	function automatic logic [7:0] noise_byte();
		if ($urandom_range(9) < 4)
			return reg_shadow[$urandom_range(5)][7:0];
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] payload_byte();
		case ($urandom_range(19))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_random_sequence();
		logic [7:0] h0, h1, tl;
		logic cfg_kind;
		int unsigned roll;
		cfg_kind = 1'($urandom_range(1));
		h0 = reg_shadow[cfg_kind ? REG_CFG_HEAD_FIRST : REG_CTRL_HEAD_FIRST][7:0];
		h1 = reg_shadow[cfg_kind ? REG_CFG_HEAD_SECOND : REG_CTRL_HEAD_SECOND][7:0];
		tl = reg_shadow[cfg_kind ? REG_CFG_TAIL_BYTE : REG_CTRL_TAIL_BYTE][7:0];
		roll = $urandom_range(99);
		if (roll < 8) begin
			send_beat(1'b1, 8'($urandom_range(255)), next_tick());
		end else if (roll < 18) begin
			repeat ($urandom_range(1, 6))
				send_beat(1'b0, noise_byte(), next_tick());
		end else if (roll < 28) begin
			// header opened, then broken or restarted
			send_beat(1'b0, h0, next_tick());
			send_beat(1'b0, noise_byte(), next_tick());
		end else begin
			send_beat(1'b0, h0, next_tick());
			send_beat(1'b0, h1, next_tick());
			repeat (6)
				send_beat(1'b0, payload_byte(), next_tick());
			if (roll < 38)
				send_beat(1'b0, tl ^ 8'($urandom_range(1, 255)), next_tick());
			else
				send_beat(1'b0, tl, ($urandom_range(29) == 0) ? 32'd0 : next_tick());
		end
	endtask

	task automatic run_traffic(input int unsigned beats);
		int unsigned stop_at;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at)
			send_random_sequence();
	endtask

	// reset values, write and readback of every register, unmapped index ignored
	task automatic test_register_access();
		int r;
		for (r = REG_CTRL_HEAD_FIRST; r <= REG_LINK_TIMEOUT_MS; r++)
			apb_read_check(3'(r));
		for (r = REG_CTRL_HEAD_FIRST; r <= REG_LINK_TIMEOUT_MS; r++) begin
			apb_write(3'(r), $urandom());
			apb_read_check(3'(r));
		end
		apb_write(REG_UNUSED, $urandom());
		for (r = REG_CTRL_HEAD_FIRST; r <= REG_LINK_TIMEOUT_MS; r++)
			apb_read_check(3'(r));
		load_settings(RST_CTRL_HEAD_FIRST, RST_CTRL_HEAD_SECOND, RST_CTRL_TAIL_BYTE,
			RST_CFG_HEAD_FIRST, RST_CFG_HEAD_SECOND, RST_CFG_TAIL_BYTE,
			RST_LINK_TIMEOUT_MS);
	endtask

	// hand-built frames on the default header set
	task automatic test_directed_frames();
		// control header then config header: restarts as config; tail at tick zero
		send_beat(1'b0, RST_CTRL_HEAD_FIRST, 32'd10);
		send_beat(1'b0, RST_CFG_HEAD_FIRST, 32'd20);
		send_beat(1'b0, RST_CFG_HEAD_SECOND, 32'd30);
		send_beat(1'b0, 8'hFF, 32'd40);
		send_beat(1'b0, 8'h00, 32'd50);
		send_beat(1'b0, 8'h1B, 32'd60);
		send_beat(1'b0, 8'hE4, 32'd70);
		send_beat(1'b0, 8'hAA, 32'd80);
		send_beat(1'b0, 8'h55, 32'd90);
		send_beat(1'b0, RST_CFG_TAIL_BYTE, 32'd0);
		send_beat(1'b1, 8'hFF, 32'hFFFF_FFFF);
		// stray byte while waiting for the second header drops the frame
		send_beat(1'b0, RST_CTRL_HEAD_FIRST, 32'd100);
		send_beat(1'b0, 8'h00, 32'd110);
		// control frame: key 11, axis extremes
		send_beat(1'b0, RST_CTRL_HEAD_FIRST, 32'd120);
		send_beat(1'b0, RST_CTRL_HEAD_SECOND, 32'd130);
		send_beat(1'b0, 8'hB5, 32'd140);
		send_beat(1'b0, 8'hFF, 32'd150);
		send_beat(1'b0, 8'h80, 32'd160);
		send_beat(1'b0, 8'h7F, 32'd170);
		send_beat(1'b0, 8'h00, 32'd180);
		send_beat(1'b0, 8'hFF, 32'd190);
		send_beat(1'b0, RST_CTRL_TAIL_BYTE, 32'd200);
		// bad tail: frame dropped, stores keep the previous frame
		send_beat(1'b0, RST_CTRL_HEAD_FIRST, 32'd250);
		send_beat(1'b0, RST_CTRL_HEAD_SECOND, 32'd260);
		send_beat(1'b0, 8'hC3, 32'd270);
		repeat (5)
			send_beat(1'b0, 8'($urandom_range(255)), 32'd280);
		send_beat(1'b0, RST_CTRL_TAIL_BYTE ^ 8'h01, 32'd300);
		// link times out
		send_beat(1'b1, 8'h00, 32'd800);
	endtask

	// traffic under several header sets, including the extremes
	task automatic test_header_settings();
		wait_idle();
		load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0);
		run_traffic(40);
		wait_idle();
		load_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		run_traffic(40);
		// shared first header: control kind always wins
		wait_idle();
		load_settings(8'h55, 8'h33, 8'hCC, 8'h55, 8'h99, 8'h66, 32'd1);
		run_traffic(40);
		repeat (2) begin
			wait_idle();
			load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 8'($urandom_range(255)),
				$urandom_range(50, 2000));
			run_traffic(40);
		end
		wait_idle();
		load_settings(RST_CTRL_HEAD_FIRST, RST_CTRL_HEAD_SECOND, RST_CTRL_TAIL_BYTE,
			RST_CFG_HEAD_FIRST, RST_CFG_HEAD_SECOND, RST_CFG_TAIL_BYTE,
			RST_LINK_TIMEOUT_MS);
	endtask

	task automatic test_random_traffic();
		run_traffic(180);
		calm = 1'b1;
		run_traffic(120);
		calm = 1'b0;
		// let the pipeline empty completely before resuming
		wait_idle();
		run_traffic(120);
	endtask

	// receiver back-pressure
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 34);

	// compare every result beat against the oldest prediction
	always @(posedge clk) begin : result_check
		telemetry_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (telemetry_due.size() == 0) begin
				report_fault("result beat with no prediction pending");
			end else begin
				want = telemetry_due.pop_front();
				check_field("frame_done", 64'(frame_done), 64'(want.done));
				check_field("frame_is_config", 64'(frame_is_config), 64'(want.is_cfg));
				check_field("key_index", 64'(key_index), 64'(want.key));
				check_field("mode_flags", 64'(mode_flags), 64'(want.mode));
				check_field("button_flags", 64'(button_flags), 64'(want.buttons));
				check_field("throttle_axis", 64'($unsigned(throttle_axis)),
					64'(want.throttle));
				check_field("steering_axis", 64'($unsigned(steering_axis)),
					64'(want.steering));
				check_field("strafe_axis", 64'($unsigned(strafe_axis)), 64'(want.strafe));
				check_field("lift_axis", 64'($unsigned(lift_axis)), 64'(want.lift));
				check_field("cell_map", 64'(cell_map), 64'(want.cells));
				check_field("config_pending", 64'(config_pending), 64'(want.pending));
				check_field("link_alive", 64'(link_alive), 64'(want.alive));
			end
		end
	end

	initial begin
		reg_shadow[REG_CTRL_HEAD_FIRST] = {24'd0, RST_CTRL_HEAD_FIRST};
		reg_shadow[REG_CTRL_HEAD_SECOND] = {24'd0, RST_CTRL_HEAD_SECOND};
		reg_shadow[REG_CTRL_TAIL_BYTE] = {24'd0, RST_CTRL_TAIL_BYTE};
		reg_shadow[REG_CFG_HEAD_FIRST] = {24'd0, RST_CFG_HEAD_FIRST};
		reg_shadow[REG_CFG_HEAD_SECOND] = {24'd0, RST_CFG_HEAD_SECOND};
		reg_shadow[REG_CFG_TAIL_BYTE] = {24'd0, RST_CFG_TAIL_BYTE};
		reg_shadow[REG_LINK_TIMEOUT_MS] = RST_LINK_TIMEOUT_MS;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_directed_frames();
		test_header_settings();
		test_random_traffic();

		wait_idle();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
